### rtl/dfd_pkg.sv
package dfd_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 4;
	localparam int FRAME_LEN_W = 11;
	localparam int OFFSET_W    = 10;
	localparam int STATUS_W    = 3;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = FRAME_LEN_W;

	localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_LEN = FRAME_LEN_W'(1024);
	localparam logic [LEN_W-1:0]       DELIM_MIN     = LEN_W'(1);
	localparam logic [LEN_W-1:0]       DELIM_MAX     = LEN_W'(8);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_START_BYTE = 3'd0,
		CFG_END_BYTE   = 3'd1,
		CFG_START_LEN  = 3'd2,
		CFG_END_LEN    = 3'd3,
		CFG_FRAME_LEN  = 3'd4
	} cfg_index_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DROP     = 3'd0,
		ST_STORED   = 3'd1,
		ST_COMPLETE = 3'd2,
		ST_ABORT    = 3'd3,
		ST_NO_BUF   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_START = 2'd1,
		PH_DATA  = 2'd2,
		PH_END   = 2'd3
	} phase_t;

	function automatic logic [LEN_W-1:0] clamp_delim(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		r = v;
		if (v < DELIM_MIN) r = DELIM_MIN;
		if (v > DELIM_MAX) r = DELIM_MAX;
		return r;
	endfunction

	function automatic logic [FRAME_LEN_W-1:0] payload_len(
		input logic [LEN_W-1:0]       start_len,
		input logic [LEN_W-1:0]       end_len,
		input logic [FRAME_LEN_W-1:0] frame_len
	);
		logic [FRAME_LEN_W-1:0] delims;
		logic [FRAME_LEN_W-1:0] fl;
		delims = FRAME_LEN_W'(clamp_delim(start_len)) + FRAME_LEN_W'(clamp_delim(end_len));
		fl = (frame_len > MAX_FRAME_LEN) ? MAX_FRAME_LEN : frame_len;
		if (fl < delims) fl = delims;
		return fl - delims;
	endfunction

endpackage

### rtl/dfd_if.sv
interface dfd_in_if import dfd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              chunk_end;
	logic              buffer_free;

	modport source (output valid, rx_byte, chunk_end, buffer_free, input ready);
	modport sink (input valid, rx_byte, chunk_end, buffer_free, output ready);
endinterface

interface dfd_out_if import dfd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   byte_out;
	logic [OFFSET_W-1:0] byte_offset;

	modport source (output valid, status, byte_out, byte_offset, input ready);
	modport sink (input valid, status, byte_out, byte_offset, output ready);
endinterface

### rtl/delimited_frame_deframer_unit.sv
// Delimited frame deframer.
// rx carries one received word per handshake: the byte, a flag that marks the
// last byte of its receive chunk, and a flag that says a frame buffer is free.
// res carries exactly one result word per accepted rx word: status, the stored
// byte and its offset within the frame (byte and offset are zero unless the
// status is byte stored or frame complete).
// Lengths and delimiter values are set through cfg_we / cfg_index / cfg_data
// while no word is in flight, which the user must ensure: the block does not
// enforce it. A length takes effect when its phase is entered. The result
// of an accepted word is registered and on res in the next cycle. Throughput
// is one word per cycle while res drains, set by the single result register.
// rx.ready is high while the result register is empty or being drained, so a
// stalled receiver stops intake after one word and nothing is lost.
// arst_n clears the config and state registers to defaults, puts the deframer
// back to hunting for a start byte and empties the result register.
module delimited_frame_deframer_unit
	import dfd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	dfd_in_if.sink                 rx,
	dfd_out_if.source              res,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [BYTE_W-1:0]      start_byte_q;
	logic [BYTE_W-1:0]      end_byte_q;
	logic [LEN_W-1:0]       start_len_q;
	logic [LEN_W-1:0]       end_len_q;
	logic [FRAME_LEN_W-1:0] frame_len_q;

	phase_t                 phase_q, phase_n;
	logic [FRAME_LEN_W-1:0] bytes_left_q, bytes_left_n;
	logic [FRAME_LEN_W-1:0] fill_pos_q, fill_pos_n;
	logic                   drop_rest_q, drop_rest_n;

	logic                   res_valid_q;
	status_t                status_q;
	logic [BYTE_W-1:0]      byte_out_q;
	logic [OFFSET_W-1:0]    byte_offset_q;

	logic                   accept;
	logic                   match_start;
	logic                   match_want;
	logic                   left_zero;
	logic [FRAME_LEN_W-1:0] left_dec;
	logic [FRAME_LEN_W-1:0] pay_len;
	logic [FRAME_LEN_W-1:0] end_left;
	logic [FRAME_LEN_W-1:0] start_left;
	status_t                status_c;
	logic                   stored_c;

	assign accept   = rx.valid && rx.ready;
	assign rx.ready = !res_valid_q || res.ready;

	assign match_start = (rx.rx_byte == start_byte_q);
	assign match_want  = (phase_q == PH_START) ? match_start : (rx.rx_byte == end_byte_q);
	assign left_zero   = (bytes_left_q == '0);
	assign left_dec    = left_zero ? '0 : bytes_left_q - FRAME_LEN_W'(1);
	assign pay_len     = payload_len(start_len_q, end_len_q, frame_len_q);
	assign end_left    = FRAME_LEN_W'(clamp_delim(end_len_q));
	assign start_left  = FRAME_LEN_W'(clamp_delim(start_len_q)) - FRAME_LEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= '0;
			end_byte_q   <= '0;
			start_len_q  <= LEN_W'(1);
			end_len_q    <= LEN_W'(1);
			frame_len_q  <= FRAME_LEN_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_BYTE: start_byte_q <= cfg_data[BYTE_W-1:0];
				CFG_END_BYTE:   end_byte_q   <= cfg_data[BYTE_W-1:0];
				CFG_START_LEN:  start_len_q  <= cfg_data[LEN_W-1:0];
				CFG_END_LEN:    end_len_q    <= cfg_data[LEN_W-1:0];
				CFG_FRAME_LEN:  frame_len_q  <= cfg_data[FRAME_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		status_c = ST_DROP;
		stored_c = 1'b0;
		if (!drop_rest_q) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (match_start) begin
						if (!rx.buffer_free) begin
							status_c = ST_NO_BUF;
						end else begin
							status_c = ST_STORED;
							stored_c = 1'b1;
						end
					end
				end
				PH_START, PH_END: begin
					if (!match_want || left_zero) begin
						status_c = ST_ABORT;
					end else begin
						stored_c = 1'b1;
						if (phase_q == PH_END && left_dec == '0) begin
							status_c = ST_COMPLETE;
						end else begin
							status_c = ST_STORED;
						end
					end
				end
				PH_DATA: begin
					status_c = ST_STORED;
					stored_c = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_n      = phase_q;
		bytes_left_n = bytes_left_q;
		fill_pos_n   = fill_pos_q;
		drop_rest_n  = drop_rest_q;
		if (drop_rest_q) begin
			if (rx.chunk_end) drop_rest_n = 1'b0;
		end else if (status_c == ST_ABORT || status_c == ST_NO_BUF) begin
			phase_n      = PH_HUNT;
			bytes_left_n = '0;
			fill_pos_n   = '0;
			drop_rest_n  = !rx.chunk_end;
		end else if (stored_c) begin
			fill_pos_n = fill_pos_q + FRAME_LEN_W'(1);
			unique case (phase_q)
				PH_HUNT, PH_START: begin
					if ((phase_q == PH_HUNT ? start_left : left_dec) != '0) begin
						phase_n      = PH_START;
						bytes_left_n = (phase_q == PH_HUNT) ? start_left : left_dec;
					end else if (pay_len == '0) begin
						phase_n      = PH_END;
						bytes_left_n = end_left;
					end else begin
						phase_n      = PH_DATA;
						bytes_left_n = pay_len;
					end
				end
				PH_DATA: begin
					if (left_dec == '0) begin
						phase_n      = PH_END;
						bytes_left_n = end_left;
					end else begin
						bytes_left_n = left_dec;
					end
				end
				PH_END: begin
					if (status_c == ST_COMPLETE) begin
						phase_n      = PH_HUNT;
						bytes_left_n = '0;
						fill_pos_n   = '0;
					end else begin
						bytes_left_n = left_dec;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			bytes_left_q <= '0;
			fill_pos_q   <= '0;
			drop_rest_q  <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_n;
			bytes_left_q <= bytes_left_n;
			fill_pos_q   <= fill_pos_n;
			drop_rest_q  <= drop_rest_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_c;
			byte_out_q    <= stored_c ? rx.rx_byte : '0;
			byte_offset_q <= stored_c ? fill_pos_q[OFFSET_W-1:0] : '0;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.status      = status_q;
	assign res.byte_out    = byte_out_q;
	assign res.byte_offset = byte_offset_q;

`ifndef SYNTH
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res.valid)
		else $error("accepted word produced no result");

	a_empty_when_not_stored: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != ST_STORED && res.status != ST_COMPLETE
		|-> res.byte_out == '0 && res.byte_offset == '0)
		else $error("byte or offset set on a result that stores nothing");

	a_hunt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HUNT |-> fill_pos_q == '0 && bytes_left_q == '0)
		else $error("hunting with a partial frame");

	a_drop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && drop_rest_q |=> res.status == ST_DROP)
		else $error("word reported while dropping the rest of a chunk");
`endif

endmodule

### tb/delimited_frame_deframer_unit_tb.sv
module delimited_frame_deframer_unit_tb;
	import dfd_pkg::*;

	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              chunk_end;
		logic              buffer_free;
	} rx_word_t;

	typedef struct packed {
		status_t             status;
		logic [BYTE_W-1:0]   byte_out;
		logic [OFFSET_W-1:0] byte_offset;
	} res_word_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	dfd_in_if  rx_if ();
	dfd_out_if res_if ();

	delimited_frame_deframer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rx_word_t  pending_rx[$];
	res_word_t due_results[$];
	int        mismatches = 0;
	int        planned    = 0;
	bit        no_idle    = 1'b0;

	logic [BYTE_W-1:0]      cfg_start_byte = '0;
	logic [BYTE_W-1:0]      cfg_end_byte   = '0;
	logic [LEN_W-1:0]       cfg_start_len  = LEN_W'(1);
	logic [LEN_W-1:0]       cfg_end_len    = LEN_W'(1);
	logic [FRAME_LEN_W-1:0] cfg_frame_len  = FRAME_LEN_W'(2);

	phase_t                 ph       = PH_HUNT;
	logic [FRAME_LEN_W-1:0] left     = '0;
	logic [FRAME_LEN_W-1:0] fill_pos = '0;
	bit                     dropping = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] v);
		if (v < DELIM_MIN) return DELIM_MIN;
		if (v > DELIM_MAX) return DELIM_MAX;
		return v;
	endfunction

	function automatic logic [FRAME_LEN_W-1:0] payload_bytes();
		logic [FRAME_LEN_W-1:0] delims;
		logic [FRAME_LEN_W-1:0] fl;
		delims = FRAME_LEN_W'(clamp_len(cfg_start_len)) + FRAME_LEN_W'(clamp_len(cfg_end_len));
		fl = (cfg_frame_len > MAX_FRAME_LEN) ? MAX_FRAME_LEN : cfg_frame_len;
		if (fl < delims) fl = delims;
		return fl - delims;
	endfunction

	function automatic void back_to_hunt();
		ph = PH_HUNT;
		left = '0;
		fill_pos = '0;
	endfunction

	function automatic void open_payload();
		left = payload_bytes();
		if (left == 0) begin
			ph = PH_END;
			left = FRAME_LEN_W'(clamp_len(cfg_end_len));
		end else begin
			ph = PH_DATA;
		end
	endfunction

	function automatic res_word_t deframe_word(rx_word_t w);
		res_word_t              r;
		bit                     stored;
		logic [FRAME_LEN_W-1:0] at;
		logic [BYTE_W-1:0]      want;
		r = '{ST_DROP, '0, '0};
		stored = 1'b0;
		at = fill_pos;
		if (dropping) begin
			if (w.chunk_end) dropping = 1'b0;
		end else if (ph == PH_HUNT) begin
			if (w.rx_byte == cfg_start_byte) begin
				if (!w.buffer_free) begin
					r.status = ST_NO_BUF;
					back_to_hunt();
					dropping = !w.chunk_end;
				end else begin
					stored = 1'b1;
					left = FRAME_LEN_W'(clamp_len(cfg_start_len)) - 1'b1;
					if (left == 0) open_payload();
					else ph = PH_START;
				end
			end
		end else if (ph == PH_START || ph == PH_END) begin
			want = (ph == PH_START) ? cfg_start_byte : cfg_end_byte;
			if (w.rx_byte != want || left == 0) begin
				r.status = ST_ABORT;
				back_to_hunt();
				dropping = !w.chunk_end;
			end else begin
				stored = 1'b1;
				left = left - 1'b1;
				if (left == 0) begin
					if (ph == PH_START) open_payload();
					else r.status = ST_COMPLETE;
				end
			end
		end else begin
			stored = 1'b1;
			if (left > 0) left = left - 1'b1;
			if (left == 0) begin
				ph = PH_END;
				left = FRAME_LEN_W'(clamp_len(cfg_end_len));
			end
		end
		if (stored) begin
			fill_pos = at + 1'b1;
			if (r.status == ST_COMPLETE) back_to_hunt();
			else r.status = ST_STORED;
			r.byte_out = w.rx_byte;
			r.byte_offset = at[OFFSET_W-1:0];
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	int tx_gap = 0;
	always @(posedge clk) begin : drive_blk
		rx_word_t w;
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
			rx_if.rx_byte <= '0;
			rx_if.chunk_end <= 1'b0;
			rx_if.buffer_free <= 1'b0;
			tx_gap = 0;
		end else if (!rx_if.valid || rx_if.ready) begin
			if (tx_gap > 0) begin
				tx_gap--;
				rx_if.valid <= 1'b0;
			end else if (pending_rx.size() > 0) begin
				w = pending_rx.pop_front();
				rx_if.rx_byte <= w.rx_byte;
				rx_if.chunk_end <= w.chunk_end;
				rx_if.buffer_free <= w.buffer_free;
				rx_if.valid <= 1'b1;
				tx_gap = no_idle ? 0 : pick_gap();
			end else begin
				rx_if.valid <= 1'b0;
			end
		end
	end

	int rcv_hold = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			rcv_hold = 0;
		end else if (rcv_hold > 0) begin
			rcv_hold--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 4) == 0) rcv_hold = pick_gap();
		end
	end

	always @(posedge clk) begin : check_blk
		res_word_t e;
		rx_word_t  w;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d byte %02h offset %0d",
							res_if.status, res_if.byte_out, res_if.byte_offset);
				end else begin
					e = due_results.pop_front();
					if (res_if.status !== e.status || res_if.byte_out !== e.byte_out ||
						res_if.byte_offset !== e.byte_offset) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("mismatch: expected status %0d byte %02h offset %0d, ",
								e.status, e.byte_out, e.byte_offset);
							$display("got status %0d byte %02h offset %0d",
								res_if.status, res_if.byte_out, res_if.byte_offset);
						end
					end
				end
			end
			if (rx_if.valid && rx_if.ready) begin
				w = '{rx_if.rx_byte, rx_if.chunk_end, rx_if.buffer_free};
				due_results.push_back(deframe_word(w));
			end
		end
	end

	int stall_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
			(pending_rx.size() == 0 && !rx_if.valid && due_results.size() == 0)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic push_word(logic [BYTE_W-1:0] b, logic ce, logic bf);
		pending_rx.push_back('{b, ce, bf});
		planned++;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_rx.size() != 0 || rx_if.valid || due_results.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_START_BYTE: cfg_start_byte = val[BYTE_W-1:0];
			CFG_END_BYTE:   cfg_end_byte = val[BYTE_W-1:0];
			CFG_START_LEN:  cfg_start_len = val[LEN_W-1:0];
			CFG_END_LEN:    cfg_end_len = val[LEN_W-1:0];
			CFG_FRAME_LEN:  cfg_frame_len = val[FRAME_LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int sb, int eb, int sl, int el, int fl);
		wait_idle();
		write_reg(CFG_START_BYTE, CFG_DATA_W'(sb));
		write_reg(CFG_END_BYTE, CFG_DATA_W'(eb));
		write_reg(CFG_START_LEN, CFG_DATA_W'(sl));
		write_reg(CFG_END_LEN, CFG_DATA_W'(el));
		write_reg(CFG_FRAME_LEN, CFG_DATA_W'(fl));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_frame(bit clean);
		int                sl;
		int                el;
		int                n;
		int                bad;
		logic [BYTE_W-1:0] b;
		sl = int'(clamp_len(cfg_start_len));
		el = int'(clamp_len(cfg_end_len));
		n = sl + el + int'(payload_bytes());
		bad = -1;
		if (!clean && $urandom_range(0, 6) == 0)
			bad = $urandom_range(0, 1) ? $urandom_range(0, sl - 1) : $urandom_range(n - el, n - 1);
		for (int i = 0; i < n; i++) begin
			if (i < sl) b = cfg_start_byte;
			else if (i >= n - el) b = cfg_end_byte;
			else b = BYTE_W'($urandom_range(0, 255));
			if (i == bad) b = b ^ BYTE_W'($urandom_range(1, 255));
			push_word(b, ($urandom_range(0, 11) == 0) || (i == n - 1 && $urandom_range(0, 1)),
				(i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 1) != 0));
		end
	endtask

	task automatic add_noise();
		int                n;
		logic [BYTE_W-1:0] b;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			b = ($urandom_range(0, 3) == 0) ? cfg_start_byte : BYTE_W'($urandom_range(0, 255));
			push_word(b, (i == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 5) == 0),
				$urandom_range(0, 3) != 0);
		end
	endtask

	task automatic fill_random(int words);
		int target;
		target = planned + words;
		while (planned < target) begin
			if ($urandom_range(0, 9) < 7) add_frame(1'b0);
			else add_noise();
		end
	endtask

	initial begin
		int sb;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		set_config(8'h7E, 8'h81, 2, 2, 7);
		push_word(8'h00, 1'b0, 1'b1);
		push_word(8'hFF, 1'b0, 1'b1);
		push_word(8'h7E, 1'b0, 1'b0);
		push_word(8'h7E, 1'b0, 1'b1);
		push_word(8'h55, 1'b1, 1'b1);
		push_word(8'h7E, 1'b1, 1'b0);
		push_word(8'h7E, 1'b0, 1'b1);
		push_word(8'h7E, 1'b0, 1'b0);
		push_word(8'hFF, 1'b0, 1'b0);
		push_word(8'h00, 1'b1, 1'b0);
		push_word(8'hAA, 1'b0, 1'b1);
		push_word(8'h81, 1'b0, 1'b0);
		push_word(8'h81, 1'b1, 1'b1);
		push_word(8'h7E, 1'b0, 1'b1);
		push_word(8'h12, 1'b0, 1'b1);
		push_word(8'h7E, 1'b0, 1'b1);
		push_word(8'h00, 1'b1, 1'b1);
		push_word(8'h7E, 1'b0, 1'b1);
		push_word(8'h7E, 1'b0, 1'b1);
		push_word(8'h01, 1'b0, 1'b1);
		push_word(8'h02, 1'b0, 1'b1);
		push_word(8'h03, 1'b0, 1'b1);
		push_word(8'h81, 1'b0, 1'b1);
		push_word(8'h7E, 1'b1, 1'b1);

		set_config(8'h00, 8'hFF, 0, 15, 0);
		fill_random(70);
		set_config(8'hFF, 8'h00, 15, 0, 20);
		fill_random(70);
		set_config(8'hA5, 8'hA5, 8, 8, 16);
		no_idle = 1'b1;
		fill_random(70);
		set_config(8'h7E, 8'h7E, $urandom_range(1, 8), $urandom_range(1, 8), 40);
		no_idle = 1'b0;
		push_word(8'h00, 1'b1, 1'b1);
		add_frame(1'b1);
		fill_random(40);
		for (int p = 0; p < 5; p++) begin
			sb = $urandom_range(0, 255);
			set_config(sb, $urandom_range(0, 1) ? sb : $urandom_range(0, 255),
				$urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 30));
			no_idle = ($urandom_range(0, 3) == 0);
			fill_random(100);
		end

		wait_idle();
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sim.f
rtl/dfd_pkg.sv
rtl/dfd_if.sv
rtl/delimited_frame_deframer_unit.sv
tb/delimited_frame_deframer_unit_tb.sv
